// File: rtl/nav_pkg.sv
// Package for the next-absent-value finder.
// Holds field widths, request codes and the scan result type.
// No dependencies; used by nav_word_scan and next_absent_value_finder_unit.
package nav_pkg;

  localparam int REQ_W      = 2;
  localparam int VALUE_W    = 10;
  localparam int RESULT_W   = 11;
  localparam int VALUE_SPAN = 1 << VALUE_W;

  // Widest bit index inside one bitmap word (words are at most 64 bits).
  localparam int BIT_IDX_W = 6;

  // Wide enough to compare against the largest universe size.
  localparam int LIM_W = 17;

  // Reciprocal used to split a value into word index and bit offset.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] idx;
  } scan_res_t;

endpackage

// File: rtl/nav_bitmap_ram.sv
// Presence bitmap storage: one write port and one registered read port.
// Depends on nothing; instantiated by next_absent_value_finder_unit.
module nav_bitmap_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nav_word_scan.sv
// Finds the lowest clear bit of one bitmap word at or above a bit offset.
// Depends on nav_pkg for the scan result type.
module nav_word_scan #(
  parameter int W = 64
) (
  input  logic [W-1:0]                  word_i,
  input  logic [nav_pkg::BIT_IDX_W-1:0] lo_i,
  output nav_pkg::scan_res_t            res_o
);

  always_comb begin
    res_o.found = 1'b0;
    res_o.idx   = '0;
    // Walk from the top down so the lowest qualifying bit wins.
    for (int i = W - 1; i >= 0; i--) begin
      if (!word_i[i] && (nav_pkg::BIT_IDX_W'(i) >= lo_i)) begin
        res_o.found = 1'b1;
        res_o.idx   = nav_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/next_absent_value_finder_unit.sv
// Next-absent-value finder: a presence bitmap with insert, query and clear.
// Depends on nav_pkg, nav_bitmap_ram and nav_word_scan.
//
// A request is taken at a clock edge where start is high and busy is low.
// req_type_i selects insert, query or clear; code 3 is dropped at once.
// Only a query answers: done_o is high for exactly one cycle with
// next_absent_o and none_free_o, and the receiver cannot hold it off.
// Steps after the accepting edge:
//   insert  busy while it splits the value, reads the word, writes it back;
//   query   splits the value, then reads and scans bitmap words, one per
//           cycle through the single RAM read port, until a result; at most
//           ceil(min(UNIVERSE_SIZE,1024) / WORD_BITS) words, 16 here;
//   clear   writes one bitmap word per cycle, 16 words with the defaults.
// A query whose bound is outside the universe, and an insert outside it,
// is answered or dropped without going busy.
// After reset the block runs the same clearing pass as a clear request,
// with busy high, one bitmap word per cycle, before the first request.
module next_absent_value_finder_unit #(
  parameter int UNIVERSE_SIZE = 1024,
  parameter int WORD_BITS     = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [nav_pkg::REQ_W-1:0]     req_type_i,
  input  logic [nav_pkg::VALUE_W-1:0]   value_i,
  output logic                          done_o,
  output logic [nav_pkg::RESULT_W-1:0]  next_absent_o,
  output logic                          none_free_o
);

  localparam int LIVE_U = (UNIVERSE_SIZE < nav_pkg::VALUE_SPAN) ?
                          UNIVERSE_SIZE : nav_pkg::VALUE_SPAN;
  localparam int LIVE_WORDS = (LIVE_U + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;
  localparam int CW = $clog2(LIVE_WORDS + 1);
  localparam int BW = $clog2(WORD_BITS);
  localparam int RECIP = ((1 << nav_pkg::RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW = nav_pkg::VALUE_W + nav_pkg::RECIP_W;
  localparam int RW = nav_pkg::RESULT_W;

  localparam logic [nav_pkg::LIM_W-1:0] U_LIM  = nav_pkg::LIM_W'(UNIVERSE_SIZE);
  localparam logic [RW-1:0]             U_RES  = RW'(UNIVERSE_SIZE);
  localparam logic [RW-1:0]             W_RES  = RW'(WORD_BITS);
  localparam logic [CW-1:0]             LAST_W = CW'(LIVE_WORDS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_DIVQ  = 3'd2;
  localparam logic [2:0] S_DIVR  = 3'd3;
  localparam logic [2:0] S_INSWR = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               ptr_q, ptr_d;
  logic                        query_q, query_d;
  logic                        first_q, first_d;
  logic [nav_pkg::VALUE_W-1:0] val_q, val_d;
  logic [BW-1:0]               bit_q, bit_d;
  logic [RW-1:0]               base_q, base_d;
  logic                        done_q, done_d;
  logic [RW-1:0]               next_q, next_d;
  logic                        full_q, full_d;

  logic                        accept;
  logic                        val_in_range;
  logic [PW-1:0]               prod;
  logic [RW-1:0]               word_base;
  logic [RW-1:0]               cand;
  logic [WORD_BITS-1:0]        rdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [WORD_BITS-1:0]        ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [nav_pkg::BIT_IDX_W-1:0] scan_lo;
  nav_pkg::scan_res_t          scan_res;

  assign accept       = start && !busy;
  assign val_in_range = nav_pkg::LIM_W'(value_i) < U_LIM;

  // Word index by reciprocal multiply; exact for every 10-bit value.
  assign prod      = PW'(val_q) * PW'(RECIP);
  assign word_base = RW'(ptr_q) * W_RES;

  assign scan_lo = first_q ? nav_pkg::BIT_IDX_W'(bit_q) : '0;
  assign cand    = base_q + (scan_res.found ? RW'(scan_res.idx) : W_RES);

  nav_bitmap_ram #(
    .DEPTH (LIVE_WORDS),
    .AW    (AW),
    .W     (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  nav_word_scan #(
    .W (WORD_BITS)
  ) u_scan (
    .word_i (rdata),
    .lo_i   (scan_lo),
    .res_o  (scan_res)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    query_d   = query_q;
    first_d   = first_q;
    val_d     = val_q;
    bit_d     = bit_q;
    base_d    = base_q;
    done_d    = 1'b0;
    next_d    = next_q;
    full_d    = full_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d   = value_i;
          query_d = (req_type_i == nav_pkg::REQ_QUERY);
          priority if (req_type_i == nav_pkg::REQ_CLEAR) begin
            ptr_d   = '0;
            state_d = S_CLEAR;
          end else if (req_type_i == nav_pkg::REQ_INSERT) begin
            if (val_in_range) begin
              state_d = S_DIVQ;
            end
          end else if (req_type_i == nav_pkg::REQ_QUERY) begin
            if (val_in_range) begin
              state_d = S_DIVQ;
            end else begin
              // Bound lies outside the universe: answer at once.
              done_d = 1'b1;
              next_d = U_RES;
              full_d = 1'b1;
            end
          end
        end
      end

      S_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + CW'(1);
        if (ptr_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end

      S_DIVQ: begin
        ptr_d   = CW'(prod[nav_pkg::RECIP_SHIFT +: AW]);
        state_d = S_DIVR;
      end

      S_DIVR: begin
        bit_d   = BW'(RW'(val_q) - word_base);
        base_d  = word_base;
        first_d = 1'b1;
        ram_re  = 1'b1;
        state_d = query_q ? S_SCAN : S_INSWR;
      end

      S_INSWR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata | (WORD_BITS'(1) << bit_q);
        state_d   = S_IDLE;
      end

      S_SCAN: begin
        if (scan_res.found || (ptr_q == LAST_W)) begin
          // Anything at or past the universe top counts as no room left.
          done_d  = 1'b1;
          full_d  = nav_pkg::LIM_W'(cand) >= U_LIM;
          next_d  = (nav_pkg::LIM_W'(cand) >= U_LIM) ? U_RES : cand;
          state_d = S_IDLE;
        end else begin
          ptr_d     = ptr_q + CW'(1);
          base_d    = base_q + W_RES;
          first_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = ptr_d[AW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      done_q  <= 1'b0;
      query_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
      query_q <= query_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    bit_q  <= bit_d;
    base_q <= base_d;
    next_q <= next_d;
    full_q <= full_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign next_absent_o = next_q;
  assign none_free_o   = full_q;

  // A result is only ever shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe while the sequencer is busy");

  a_full_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && none_free_o) |-> (next_absent_o == U_RES))
    else $error("full flag without the universe size as answer");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !none_free_o) |-> (nav_pkg::LIM_W'(next_absent_o) < U_LIM))
    else $error("free answer outside the universe");

  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) || (state_q == S_INSWR) || (state_q == S_CLEAR))
      |-> (ptr_q <= LAST_W))
    else $error("word pointer past the last bitmap word");

  a_query_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == nav_pkg::REQ_QUERY) && !val_in_range) |=> done_o)
    else $error("out-of-universe query not answered at once");

endmodule
